>>> rtl/dxtbd_pkg.sv
// Shared types, constants and helper functions for the DXT1/DXT3 block decoder.
// No dependencies.
package dxtbd_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned PixelW = 32;
  localparam int unsigned RgbW   = 24;

  localparam logic [7:0] Weight1 = 8'h55;
  localparam logic [7:0] Weight2 = 8'haa;
  localparam logic [7:0] Opaque  = 8'hff;
  localparam logic [7:0] Clear   = 8'h00;
  localparam logic [1:0] LastRow = 2'd3;
  localparam logic [1:0] IdxFour = 2'd3;

  typedef logic [RgbW-1:0] rgb_t;

  typedef struct packed {
    rgb_t [3:0] entry;
    logic       greater;
  } pal_t;

  // RGB565 to packed 8:8:8 by bit replication
  function automatic rgb_t widen565(input logic [15:0] v);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = v[15:11];
    g = v[10:5];
    b = v[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  // a + floor((t + floor(t/256)) / 256), t = (b - a) * w + 128
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] w);
    logic signed [17:0] d;
    logic signed [17:0] t;
    logic signed [17:0] s;
    logic signed [17:0] r;
    d = $signed({10'b0, b}) - $signed({10'b0, a});
    t = d * $signed({10'b0, w}) + 18'sd128;
    s = t + (t >>> 8);
    r = $signed({10'b0, a}) + (s >>> 8);
    return r[7:0];
  endfunction

  function automatic logic [7:0] mean(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b} + 9'd1;
    return sum[8:1];
  endfunction

endpackage

>>> rtl/dxtbd_palette.sv
// Builds the four-entry color palette from the two RGB565 endpoints.
// Depends on dxtbd_pkg.
module dxtbd_palette (
  input  logic [31:0]     endpoints_i,
  output dxtbd_pkg::pal_t pal_o
);

  logic [15:0]      c0;
  logic [15:0]      c1;
  dxtbd_pkg::rgb_t  p0;
  dxtbd_pkg::rgb_t  p1;
  dxtbd_pkg::rgb_t  e2;
  dxtbd_pkg::rgb_t  e3;
  logic             greater;

  assign c0      = endpoints_i[15:0];
  assign c1      = endpoints_i[31:16];
  assign p0      = dxtbd_pkg::widen565(c0);
  assign p1      = dxtbd_pkg::widen565(c1);
  assign greater = c0 > c1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (greater) begin
        e2[8*k +: 8] = dxtbd_pkg::blend(p0[8*k +: 8], p1[8*k +: 8], dxtbd_pkg::Weight1);
        e3[8*k +: 8] = dxtbd_pkg::blend(p0[8*k +: 8], p1[8*k +: 8], dxtbd_pkg::Weight2);
      end else begin
        e2[8*k +: 8] = dxtbd_pkg::mean(p0[8*k +: 8], p1[8*k +: 8]);
        e3[8*k +: 8] = dxtbd_pkg::Opaque;
      end
    end
  end

  assign pal_o.entry   = {e3, e2, p1, p0};
  assign pal_o.greater = greater;

endmodule

>>> rtl/dxtbd_row_sel.sv
// Picks palette colors and alpha for the four pixels of one row.
// Depends on dxtbd_pkg.
module dxtbd_row_sel (
  input  dxtbd_pkg::pal_t pal_i,
  input  logic [7:0]      idx_row_i,
  input  logic [15:0]     alpha_row_i,
  input  logic            mode_dxt3_i,
  output logic [3:0][31:0] pixel_o
);

  always_comb begin
    for (int x = 0; x < 4; x++) begin
      logic [1:0] idx;
      logic [3:0] nib;
      logic [7:0] alpha;
      idx = idx_row_i[2*x +: 2];
      nib = alpha_row_i[4*x +: 4];
      if (mode_dxt3_i) begin
        alpha = {nib, nib};
      end else if (!pal_i.greater && idx == dxtbd_pkg::IdxFour) begin
        alpha = dxtbd_pkg::Clear;
      end else begin
        alpha = dxtbd_pkg::Opaque;
      end
      pixel_o[x] = {pal_i.entry[idx], alpha};
    end
  end

endmodule

>>> rtl/dxt1_dxt3_block_decoder.sv
// Top level of the DXT1/DXT3 block decoder: block register, row control, output register.
// Depends on dxtbd_pkg, dxtbd_palette and dxtbd_row_sel.
//
// channel | signals                                  | dir | word
// in      | in_valid_i in_ready_o                    | in  | color_block_i, alpha_block_i
// out     | out_valid_o out_ready_i                  | out | pixel_a..d_o, row_index_o, last_row_o
// cfg     | cfg_valid_i cfg_ready_o                  | in  | cfg_mode_dxt3_i
//
// One block in, four row words out, one row per cycle while the output is not stalled.
// The next block is taken in the cycle its predecessor's last row moves to the
// output, so blocks stream back to back without a gap.
// Output stalls hold the row counter and block register. Reset empties both
// stages and clears mode_dxt3. cfg_ready_o is always high.
module dxt1_dxt3_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_mode_dxt3_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] color_block_i,
  input  logic [63:0] alpha_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_a_o,
  output logic [31:0] pixel_b_o,
  output logic [31:0] pixel_c_o,
  output logic [31:0] pixel_d_o,
  output logic [1:0]  row_index_o,
  output logic        last_row_o
);

  logic            mode_q;
  logic            busy_q, busy_d;
  logic [1:0]      row_q, row_d;
  logic [63:0]     color_q;
  logic [63:0]     alpha_q;
  logic            out_valid_q, out_valid_d;
  logic [3:0][31:0] pix_q;
  logic [1:0]      out_row_q;

  logic            advance;
  logic            load_out;
  logic            in_take;
  dxtbd_pkg::pal_t pal;
  logic [3:0][31:0] pix_d;

  assign cfg_ready_o = 1'b1;
  assign advance     = out_ready_i || !out_valid_q;
  assign load_out    = busy_q && advance;
  assign in_ready_o  = !busy_q || (advance && row_q == dxtbd_pkg::LastRow);
  assign in_take     = in_valid_i && in_ready_o;

  dxtbd_palette u_palette (
    .endpoints_i (color_q[31:0]),
    .pal_o       (pal)
  );

  dxtbd_row_sel u_row_sel (
    .pal_i       (pal),
    .idx_row_i   (color_q[{1'b1, row_q, 3'b000} +: 8]),
    .alpha_row_i (alpha_q[{row_q, 4'b0000} +: 16]),
    .mode_dxt3_i (mode_q),
    .pixel_o     (pix_d)
  );

  always_comb begin
    busy_d      = busy_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = busy_q;
    end
    if (load_out) begin
      row_d = row_q + 2'd1;
      if (row_q == dxtbd_pkg::LastRow) begin
        busy_d = 1'b0;
      end
    end
    if (in_take) begin
      busy_d = 1'b1;
      row_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      busy_q      <= 1'b0;
      row_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_mode_dxt3_i;
      end
      busy_q      <= busy_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      color_q <= color_block_i;
      alpha_q <= alpha_block_i;
    end
    if (load_out) begin
      pix_q     <= pix_d;
      out_row_q <= row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_a_o   = pix_q[0];
  assign pixel_b_o   = pix_q[1];
  assign pixel_c_o   = pix_q[2];
  assign pixel_d_o   = pix_q[3];
  assign row_index_o = out_row_q;
  assign last_row_o  = out_row_q == dxtbd_pkg::LastRow;

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> busy_q)
    else $error("accepted block did not mark the decoder busy");

  a_ready_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && in_ready_o |-> row_q == dxtbd_pkg::LastRow && advance)
    else $error("new block taken before last row left");

  a_rows_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> out_valid_o)
    else $error("gap inside a block's rows");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> row_index_o == $past(row_index_o) + 2'd1)
    else $error("rows out of order");

endmodule

>>> verif/dxt1_dxt3_block_decoder_tb.sv
// Testbench for dxt1_dxt3_block_decoder: drives compressed blocks and mode writes with random
// idling and back-pressure, predicts the four row words of each block and checks every field.
// Depends on dxtbd_pkg and the decoder RTL.
module dxt1_dxt3_block_decoder_tb;

  localparam int HoldCycles   = 200;
  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 10;
  localparam int PrintLimit   = 50;

  typedef struct packed {
    logic [3:0][dxtbd_pkg::PixelW-1:0] px;
    logic [1:0]                        row;
    logic                              last;
  } row_word_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic                         cfg_mode_dxt3_i = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [dxtbd_pkg::BlockW-1:0] color_block_i = '0;
  logic [dxtbd_pkg::BlockW-1:0] alpha_block_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [dxtbd_pkg::PixelW-1:0] pixel_a_o;
  logic [dxtbd_pkg::PixelW-1:0] pixel_b_o;
  logic [dxtbd_pkg::PixelW-1:0] pixel_c_o;
  logic [dxtbd_pkg::PixelW-1:0] pixel_d_o;
  logic [1:0]                   row_index_o;
  logic                         last_row_o;

  row_word_t rows_due[$];
  logic      mode_dxt3_q = 1'b0;
  int        mismatches = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_reqs = 0;
  int        holds_done = 0;
  int        hold_left = 0;
  int        idle_cycles = 0;

  dxt1_dxt3_block_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_mode_dxt3_i (cfg_mode_dxt3_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .color_block_i   (color_block_i),
    .alpha_block_i   (alpha_block_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_a_o       (pixel_a_o),
    .pixel_b_o       (pixel_b_o),
    .pixel_c_o       (pixel_c_o),
    .pixel_d_o       (pixel_d_o),
    .row_index_o     (row_index_o),
    .last_row_o      (last_row_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [23:0] expand565(input logic [15:0] v);
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r8 = {v[15:11], 3'b000} | {5'b00000, v[15:13]};
    g8 = {v[10:5], 2'b00} | {6'b000000, v[10:9]};
    b8 = {v[4:0], 3'b000} | {5'b00000, v[4:2]};
    return {r8, g8, b8};
  endfunction

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b, input int w);
    int t;
    int s;
    int r;
    t = (int'(b) - int'(a)) * w + 128;
    s = t + (t >>> 8);
    r = int'(a) + (s >>> 8);
    return r[7:0];
  endfunction

  // palette build plus per-pixel alpha, four row words per block
  task automatic predict_block(input logic [dxtbd_pkg::BlockW-1:0] color,
                               input logic [dxtbd_pkg::BlockW-1:0] alpha);
    logic [15:0] c0;
    logic [15:0] c1;
    logic [23:0] pal [4];
    logic        gt;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [8:0]  sum;
    logic [7:0]  idxrow;
    logic [15:0] arow;
    logic [1:0]  idx;
    logic [7:0]  a8;
    row_word_t   w;
    c0 = color[15:0];
    c1 = color[31:16];
    gt = c0 > c1;
    pal[0] = expand565(c0);
    pal[1] = expand565(c1);
    for (int k = 0; k < 3; k++) begin
      a = pal[0][8*k +: 8];
      b = pal[1][8*k +: 8];
      if (gt) begin
        pal[2][8*k +: 8] = lerp8(a, b, int'(dxtbd_pkg::Weight1));
        pal[3][8*k +: 8] = lerp8(a, b, int'(dxtbd_pkg::Weight2));
      end else begin
        sum = {1'b0, a} + {1'b0, b} + 9'd1;
        pal[2][8*k +: 8] = sum[8:1];
        pal[3][8*k +: 8] = dxtbd_pkg::Opaque;
      end
    end
    for (int y = 0; y < 4; y++) begin
      idxrow = color[32 + 8*y +: 8];
      arow = alpha[16*y +: 16];
      for (int x = 0; x < 4; x++) begin
        idx = idxrow[2*x +: 2];
        if (mode_dxt3_q) a8 = {4'b0000, arow[4*x +: 4]} * 8'd17;
        else a8 = (!gt && idx == dxtbd_pkg::IdxFour) ? dxtbd_pkg::Clear : dxtbd_pkg::Opaque;
        w.px[x] = {pal[idx], a8};
      end
      w.row = y[1:0];
      w.last = (w.row == dxtbd_pkg::LastRow);
      rows_due.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PrintLimit)
      $display("row word %s: got %h, want %h", what, got, want);
  endtask

  // out_ready_i: random idling, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    row_word_t got;
    row_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.px = {pixel_d_o, pixel_c_o, pixel_b_o, pixel_a_o};
      got.row = row_index_o;
      got.last = last_row_o;
      if (rows_due.size() == 0) begin
        report_mismatch("with none pending", got.px[0], '0);
      end else begin
        want = rows_due.pop_front();
        for (int i = 0; i < 4; i++)
          if (got.px[i] !== want.px[i])
            report_mismatch($sformatf("pixel col %0d", i), got.px[i], want.px[i]);
        if (got.row !== want.row) report_mismatch("row_index", 32'(got.row), 32'(want.row));
        if (got.last !== want.last) report_mismatch("last_row", 32'(got.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("dxt1_dxt3_block_decoder: mismatch");
      $finish;
    end
  end

  task automatic send_block(input logic [dxtbd_pkg::BlockW-1:0] color,
                            input logic [dxtbd_pkg::BlockW-1:0] alpha);
    in_valid_i <= 1'b1;
    color_block_i <= color;
    alpha_block_i <= alpha;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_block(color, alpha);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_mode_dxt3_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_dxt3_q = m;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [dxtbd_pkg::BlockW-1:0] rand_color();
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] tmp;
    int          kind;
    c0 = 16'($urandom);
    c1 = 16'($urandom);
    kind = $urandom_range(9);
    if (kind == 0) begin
      c1 = c0;
    end else if ((kind < 6 && c0 < c1) || (kind >= 6 && c0 > c1)) begin
      tmp = c0;
      c0 = c1;
      c1 = tmp;
    end
    return {32'($urandom), c1, c0};
  endfunction

  task automatic test_directed_dxt1();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    set_mode(1'b0);
    send_block(64'h0, {$urandom, $urandom});
    send_block({64{1'b1}}, {$urandom, $urandom});
    send_block(64'he4e4e4e4_0000ffff, 64'h0);
    send_block(64'he4e4e4e4_ffff0000, {64{1'b1}});
    send_block(64'h1b1b1b1b_001ff800, {$urandom, $urandom});
    send_block(64'haa55ff00_07df07e0, {$urandom, $urandom});
    send_block(64'he4e4e4e4_84108410, {$urandom, $urandom});
    send_block(64'hffffffff_00000001, {$urandom, $urandom});
  endtask

  task automatic test_directed_dxt3();
    set_mode(1'b1);
    send_block(64'he4e4e4e4_0000ffff, 64'h0);
    send_block(64'he4e4e4e4_ffff0000, {64{1'b1}});
    send_block(64'hffffffff_84108410, 64'hfedcba98_76543210);
    send_block(64'h1b1b1b1b_f81f07e0, 64'h01234567_89abcdef);
    send_block({64{1'b1}}, 64'hf0f00f0f_5a5aa5a5);
    send_block(64'h0, {64{1'b1}});
  endtask

  task automatic test_random(input int n, input int tx_pct, input int rx_pct, input logic m);
    set_mode(m);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) send_block(rand_color(), {$urandom, $urandom});
  endtask

  // receiver stalls while the sender keeps offering words
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_reqs++;
    repeat (12) send_block(rand_color(), {$urandom, $urandom});
  endtask

  task automatic test_drain_pause();
    set_mode(1'b0);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    repeat (4) send_block(rand_color(), {$urandom, $urandom});
    wait_idle();
    repeat (4) send_block(rand_color(), {$urandom, $urandom});
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_dxt1();
    test_directed_dxt3();
    test_random(24, 30, 80, 1'b1);
    test_random(24, 80, 30, 1'b0);
    test_random(24, 0, 0, 1'b1);
    test_backpressure();
    test_drain_pause();
    wait_idle();
    if (mismatches == 0) begin
      $display("dxt1_dxt3_block_decoder: match");
    end else begin
      $display("dxt1_dxt3_block_decoder: mismatch");
    end
    $finish;
  end

endmodule

>>> dxt1_dxt3_block_decoder.f
rtl/dxtbd_pkg.sv
rtl/dxtbd_palette.sv
rtl/dxtbd_row_sel.sv
rtl/dxt1_dxt3_block_decoder.sv
verif/dxt1_dxt3_block_decoder_tb.sv
